[hw/rtl/midi_rule_filter_mapper_unit_macros.svh]
// assertion macros for the midi rule filter and mapper
`ifndef MIDI_RULE_FILTER_MAPPER_UNIT_MACROS_SVH
`define MIDI_RULE_FILTER_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MRFM_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`define MRFM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MRFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRFM_ASSERT_HOLD(label, cond, msg)
`define MRFM_ASSERT_IMPL(label, ante, cons, msg)
`define MRFM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hw/rtl/mrfm_pkg.sv]
// types, constants and rule slot decoder for the midi rule filter and mapper
package mrfm_pkg;

    localparam int NUM_RULES  = 10;
    localparam int SLOT_COUNT = 10;
    localparam int SLOT_W     = 16;
    localparam int IDX_W      = 4;

    localparam logic [IDX_W-1:0] RULE_LIMIT = IDX_W'(NUM_RULES);
    localparam logic [IDX_W-1:0] SLOT_LIMIT = IDX_W'(SLOT_COUNT);

    localparam logic [6:0] TGT_DISCARD  = 7'd0;
    localparam logic [6:0] TGT_FIRST_CH = 7'd1;
    localparam logic [6:0] TGT_KEY_AT   = 7'd17;
    localparam logic [6:0] TGT_CHAN_AT  = 7'd18;
    localparam logic [6:0] TGT_PROG     = 7'd19;
    localparam logic [6:0] TGT_FIRST_CC = 7'd21;
    localparam logic [6:0] TGT_LAST_CC  = 7'd84;

    localparam logic [3:0] ST_KEY_AT  = 4'hA;
    localparam logic [3:0] ST_CTRL    = 4'hB;
    localparam logic [3:0] ST_PROG    = 4'hC;
    localparam logic [3:0] ST_CHAN_AT = 4'hD;
    localparam logic [3:0] ST_PITCH   = 4'hE;
    localparam logic [3:0] ST_SYSTEM  = 4'hF;

    localparam logic [1:0] LEN_ONE = 2'd1;
    localparam logic [1:0] LEN_TWO = 2'd2;

    localparam logic [1:0] REG_RULE_COUNT = 2'd0;
    localparam logic [1:0] REG_SLOTS_0_3  = 2'd1;
    localparam logic [1:0] REG_SLOTS_4_7  = 2'd2;
    localparam logic [1:0] REG_SLOTS_8_9  = 2'd3;

    localparam logic [3:0]  RST_RULE_COUNT = 4'd0;
    localparam logic [63:0] RST_SLOTS_0_3  = 64'h0005_0005_0005_0005;
    localparam logic [63:0] RST_SLOTS_4_7  = 64'h0005_0005_0005_0005;
    localparam logic [31:0] RST_SLOTS_8_9  = 32'h0005_0005;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        MK_CHAN = 2'd0,
        MK_TYPE = 2'd1,
        MK_CC   = 2'd2
    } t_match_kind;

    typedef enum logic [2:0] {
        ACT_OFF      = 3'd0,
        ACT_DISCARD  = 3'd1,
        ACT_SET_CHAN = 3'd2,
        ACT_SET_CC   = 3'd3,
        ACT_AT_TO_CC = 3'd4,
        ACT_CC_TO_AT = 3'd5
    } t_action;

    typedef struct packed {
        logic [1:0]  src;
        t_match_kind kind;
        t_action     act;
        logic [3:0]  match_chan;
        logic [3:0]  match_type;
        logic [5:0]  match_cc;
        logic [5:0]  arg;
    } t_rule;

    function automatic t_rule rule_decode(input t_slot slot);
        t_rule      r;
        logic [6:0] tin;
        logic [6:0] tout;
        logic [6:0] tin_cc;
        logic [6:0] tout_cc;
        logic [6:0] tin_ch;
        logic [6:0] tout_ch;
        logic       tout_is_cc;
        tin        = slot[8:2];
        tout       = slot[15:9];
        tin_cc     = tin - TGT_FIRST_CC;
        tout_cc    = tout - TGT_FIRST_CC;
        tin_ch     = tin - TGT_FIRST_CH;
        tout_ch    = tout - TGT_FIRST_CH;
        tout_is_cc = (tout >= TGT_FIRST_CC) && (tout <= TGT_LAST_CC);
        r.src        = slot[1:0];
        r.kind       = MK_TYPE;
        r.act        = ACT_OFF;
        r.match_chan = 4'd0;
        r.match_type = 4'd0;
        r.match_cc   = 6'd0;
        r.arg        = 6'd0;
        priority if (tin == TGT_DISCARD || tin > TGT_LAST_CC) begin
            r.act = ACT_OFF;
        end else if (tin < TGT_KEY_AT) begin
            r.kind       = MK_CHAN;
            r.match_chan = tin_ch[3:0];
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (tout < TGT_KEY_AT) begin
                r.act = ACT_SET_CHAN;
                r.arg = {2'b00, tout_ch[3:0]};
            end
        end else if (tin >= TGT_FIRST_CC) begin
            r.kind       = MK_CC;
            r.match_type = ST_CTRL;
            r.match_cc   = tin_cc[5:0];
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (tout_is_cc) begin
                r.act = ACT_SET_CC;
                r.arg = tout_cc[5:0];
            end else if (tout == TGT_CHAN_AT) begin
                r.act = ACT_CC_TO_AT;
            end
        end else if (tin == TGT_CHAN_AT) begin
            r.match_type = ST_CHAN_AT;
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (tout_is_cc) begin
                r.act = ACT_AT_TO_CC;
                r.arg = tout_cc[5:0];
            end
        end else begin
            priority if (tin == TGT_KEY_AT) begin
                r.match_type = ST_KEY_AT;
            end else if (tin == TGT_PROG) begin
                r.match_type = ST_PROG;
            end else begin
                r.match_type = ST_PITCH;
            end
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/midi_rule_filter_mapper_unit.sv]
// top level of the midi rule filter and mapper
// system messages and items with zero active rules skip the rule pass; else n rules are applied,
// n = min(rule_count, 10), fewer after a discard, one rule per cycle through the single
// decode and match unit; one item in flight, the next accepted back in idle after the
// result is taken, where a waiting register write goes first
// synchronous active-low reset clears control state and restores the register defaults
`include "midi_rule_filter_mapper_unit_macros.svh"

module midi_rule_filter_mapper_unit
    import mrfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // status_byte, first_data, second_data, data_length, source_ports, zero fill
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_status, out_first_data, out_second_data, out_length, drop_flag, zero fill
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_limit, n_limit;
    logic             r_drop, n_drop;
    logic [7:0]       r_st, n_st;
    logic [7:0]       r_d0, n_d0;
    logic [7:0]       r_d1, n_d1;
    logic [1:0]       r_len, n_len;
    logic [1:0]       r_ports, n_ports;

    logic [3:0]  r_rule_count;
    logic [63:0] r_slots_0_3;
    logic [63:0] r_slots_4_7;
    logic [31:0] r_slots_8_9;

    logic [SLOT_COUNT*SLOT_W-1:0] w_all_slots;
    t_slot                        w_slot_arr [SLOT_COUNT];
    t_slot                        w_slot;
    t_rule                        w_rule;
    logic                         w_hit;
    logic                         w_fire;
    logic                         w_in_acc;
    logic [IDX_W-1:0]             w_idx_inc;
    logic [IDX_W-1:0]             w_limit_in;

    // register writes only while idle, and they go before a waiting item
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_m_tdata   = {5'd0, r_drop, r_len, r_d1, r_d0, r_st};
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_idx_inc   = r_idx + IDX_W'(1);

    assign w_all_slots = {r_slots_8_9, r_slots_4_7, r_slots_0_3};

    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            w_slot_arr[k] = w_all_slots[k*SLOT_W +: SLOT_W];
        end
    end

    // slots past the register set act as rules that are off
    assign w_slot = (r_idx < SLOT_LIMIT) ? w_slot_arr[r_idx] : t_slot'(0);
    assign w_rule = rule_decode(w_slot);

    always_comb begin
        unique case (w_rule.kind)
            MK_CHAN: w_hit = (r_st[3:0] == w_rule.match_chan);
            MK_TYPE: w_hit = (r_st[7:4] == w_rule.match_type);
            MK_CC:   w_hit = (r_st[7:4] == w_rule.match_type) &&
                             (r_d0 == {2'b00, w_rule.match_cc});
            default: w_hit = 1'b0;
        endcase
    end

    assign w_fire = (|(r_ports & w_rule.src)) && w_hit;

    assign w_limit_in = (i_s_tdata[7:4] == ST_SYSTEM) ? IDX_W'(0) :
                        (IDX_W'(r_rule_count) > RULE_LIMIT) ? RULE_LIMIT :
                        IDX_W'(r_rule_count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_limit = r_limit;
        n_drop  = r_drop;
        n_st    = r_st;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_len   = r_len;
        n_ports = r_ports;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_st    = i_s_tdata[7:0];
                    n_d0    = i_s_tdata[15:8];
                    n_d1    = i_s_tdata[23:16];
                    n_len   = i_s_tdata[25:24];
                    n_ports = i_s_tdata[27:26];
                    n_drop  = 1'b0;
                    n_idx   = '0;
                    n_limit = w_limit_in;
                    n_state = (w_limit_in == IDX_W'(0)) ? S_OUT : S_RUN;
                end
            end
            S_RUN: begin
                if (w_fire) begin
                    unique case (w_rule.act)
                        ACT_DISCARD:  n_drop = 1'b1;
                        ACT_SET_CHAN: n_st = {r_st[7:4], w_rule.arg[3:0]};
                        ACT_SET_CC:   n_d0 = {2'b00, w_rule.arg};
                        ACT_AT_TO_CC: begin
                            n_st  = {ST_CTRL, r_st[3:0]};
                            n_d1  = r_d0;
                            n_d0  = {2'b00, w_rule.arg};
                            n_len = LEN_TWO;
                        end
                        ACT_CC_TO_AT: begin
                            n_st  = {ST_CHAN_AT, r_st[3:0]};
                            n_d0  = r_d1;
                            n_len = LEN_ONE;
                        end
                        default: ;
                    endcase
                end
                n_idx = w_idx_inc;
                if ((w_fire && w_rule.act == ACT_DISCARD) || w_idx_inc == r_limit) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_limit      <= '0;
            r_drop       <= 1'b0;
            r_rule_count <= RST_RULE_COUNT;
            r_slots_0_3  <= RST_SLOTS_0_3;
            r_slots_4_7  <= RST_SLOTS_4_7;
            r_slots_8_9  <= RST_SLOTS_8_9;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_limit <= n_limit;
            r_drop  <= n_drop;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_RULE_COUNT: r_rule_count <= i_cfg_data[3:0];
                    REG_SLOTS_0_3:  r_slots_0_3  <= i_cfg_data;
                    REG_SLOTS_4_7:  r_slots_4_7  <= i_cfg_data;
                    REG_SLOTS_8_9:  r_slots_8_9  <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st    <= n_st;
        r_d0    <= n_d0;
        r_d1    <= n_d1;
        r_len   <= n_len;
        r_ports <= n_ports;
    end

    `MRFM_ASSERT_IMPL(a_idx_in_range, r_state == S_RUN, r_idx < r_limit, "rule index past limit")
    `MRFM_ASSERT_IMPL(a_no_run_after_drop, r_state == S_RUN, !r_drop, "rule applied after discard")
    `MRFM_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == S_RUN || r_state == S_OUT,
        "accepted item not started")
    `MRFM_ASSERT_NEXT(a_out_holds, r_state == S_OUT && !i_m_tready, r_state == S_OUT,
        "result dropped before taken")
    `MRFM_ASSERT_HOLD(a_limit_bound, r_limit <= RULE_LIMIT, "rule limit above rule count cap")

endmodule

[verif/midi_rule_filter_mapper_unit_check.sv]
// checker for the midi rule filter and mapper: tracks registers, predicts and compares results
module midi_rule_filter_mapper_unit_check
    import mrfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       drop;
        logic [1:0] len;
        logic [7:0] d1;
        logic [7:0] d0;
        logic [7:0] st;
    } t_midi_result;

    logic [3:0]   rule_count;
    logic [63:0]  slots_0_3;
    logic [63:0]  slots_4_7;
    logic [31:0]  slots_8_9;
    t_midi_result pending_results[$];
    int           errors = 0;

    function automatic t_rule rule_of_slot(input t_slot s);
        t_rule      r;
        logic [6:0] tin;
        logic [6:0] tout;
        logic       out_cc;
        tin    = s[8:2];
        tout   = s[15:9];
        out_cc = (tout >= TGT_FIRST_CC) && (tout <= TGT_LAST_CC);
        r      = '0;
        r.src  = s[1:0];
        r.kind = MK_TYPE;
        r.act  = ACT_OFF;
        if (tin == TGT_DISCARD || tin > TGT_LAST_CC) begin
            r.act = ACT_OFF;
        end else if (tin < TGT_KEY_AT) begin
            r.kind       = MK_CHAN;
            r.match_chan = 4'(tin - TGT_FIRST_CH);
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (tout < TGT_KEY_AT) begin
                r.act = ACT_SET_CHAN;
                r.arg = 6'(tout - TGT_FIRST_CH);
            end
        end else if (tin >= TGT_FIRST_CC) begin
            r.kind       = MK_CC;
            r.match_type = ST_CTRL;
            r.match_cc   = 6'(tin - TGT_FIRST_CC);
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (out_cc) begin
                r.act = ACT_SET_CC;
                r.arg = 6'(tout - TGT_FIRST_CC);
            end else if (tout == TGT_CHAN_AT) begin
                r.act = ACT_CC_TO_AT;
            end
        end else if (tin == TGT_CHAN_AT) begin
            r.match_type = ST_CHAN_AT;
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end else if (out_cc) begin
                r.act = ACT_AT_TO_CC;
                r.arg = 6'(tout - TGT_FIRST_CC);
            end
        end else begin
            if (tin == TGT_KEY_AT) begin
                r.match_type = ST_KEY_AT;
            end else if (tin == TGT_PROG) begin
                r.match_type = ST_PROG;
            end else begin
                r.match_type = ST_PITCH;
            end
            if (tout == TGT_DISCARD) begin
                r.act = ACT_DISCARD;
            end
        end
        return r;
    endfunction

    function automatic t_midi_result mapped_message(input logic [31:0] word);
        t_midi_result res;
        t_rule        rl;
        logic [1:0]   ports;
        logic [159:0] all_slots;
        int           active;
        int           k;
        logic         hit;
        res.st    = word[7:0];
        res.d0    = word[15:8];
        res.d1    = word[23:16];
        res.len   = word[25:24];
        res.drop  = 1'b0;
        ports     = word[27:26];
        all_slots = {slots_8_9, slots_4_7, slots_0_3};
        if (res.st[7:4] != ST_SYSTEM) begin
            active = (int'(rule_count) > NUM_RULES) ? NUM_RULES : int'(rule_count);
            for (k = 0; k < active && !res.drop; k++) begin
                rl = rule_of_slot(all_slots[16*k +: 16]);
                if ((ports & rl.src) == 2'b00 || rl.act == ACT_OFF) begin
                    continue;
                end
                case (rl.kind)
                    MK_CHAN: hit = (res.st[3:0] == rl.match_chan);
                    MK_CC:   hit = (res.st[7:4] == rl.match_type) && (res.d0 == {2'b00, rl.match_cc});
                    default: hit = (res.st[7:4] == rl.match_type);
                endcase
                if (!hit) begin
                    continue;
                end
                case (rl.act)
                    ACT_DISCARD: begin
                        res.drop = 1'b1;
                    end
                    ACT_SET_CHAN: begin
                        res.st = {res.st[7:4], rl.arg[3:0]};
                    end
                    ACT_SET_CC: begin
                        res.d0 = {2'b00, rl.arg};
                    end
                    ACT_AT_TO_CC: begin
                        res.st  = {ST_CTRL, res.st[3:0]};
                        res.d1  = res.d0;
                        res.d0  = {2'b00, rl.arg};
                        res.len = LEN_TWO;
                    end
                    ACT_CC_TO_AT: begin
                        res.st  = {ST_CHAN_AT, res.st[3:0]};
                        res.d0  = res.d1;
                        res.len = LEN_ONE;
                    end
                    default: begin
                    end
                endcase
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_midi_result seen;
        t_midi_result want;
        if (!i_rst_n) begin
            rule_count = RST_RULE_COUNT;
            slots_0_3  = RST_SLOTS_0_3;
            slots_4_7  = RST_SLOTS_4_7;
            slots_8_9  = RST_SLOTS_8_9;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[26:0];
                if (pending_results.size() == 0) begin
                    $error("result item with nothing expected: %h", i_m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_status", want.st, seen.st);
                    check_field("out_first_data", want.d0, seen.d0);
                    check_field("out_second_data", want.d1, seen.d1);
                    check_field("out_length", want.len, seen.len);
                    check_field("drop_flag", want.drop, seen.drop);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RULE_COUNT: rule_count = i_cfg_data[3:0];
                    REG_SLOTS_0_3:  slots_0_3  = i_cfg_data;
                    REG_SLOTS_4_7:  slots_4_7  = i_cfg_data;
                    REG_SLOTS_8_9:  slots_8_9  = i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_results.push_back(mapped_message(i_s_tdata));
            end
        end
        o_errors  <= errors;
        o_pending <= pending_results.size();
    end

endmodule

[verif/midi_rule_filter_mapper_unit_test.sv]
// testbench top for the midi rule filter and mapper: stimulus, register setup and verdict
module midi_rule_filter_mapper_unit_test
    import mrfm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;
    int          errors;
    int          pending;
    bit          quiet = 1'b0;

    midi_rule_filter_mapper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    midi_rule_filter_mapper_unit_check checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[midi_rule_filter_mapper_unit] ERROR");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    function automatic logic [15:0] rule_slot(input logic [1:0] src, input logic [6:0] tin,
                                              input logic [6:0] tout);
        return {tout, tin, src};
    endfunction

    function automatic logic [31:0] pack_message(input logic [7:0] st, input logic [7:0] d0,
                                                 input logic [7:0] d1, input logic [1:0] len,
                                                 input logic [1:0] ports);
        return {4'b0000, ports, len, d1, d0, st};
    endfunction

    function automatic logic [15:0] random_rule();
        logic [1:0] src;
        logic [6:0] tin;
        logic [6:0] tout;
        logic [6:0] chan_off;
        logic [6:0] cc;
        src      = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        cc       = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7))
                                               : 7'($urandom_range(0, 63));
        chan_off = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 3))
                                               : 7'($urandom_range(0, 15));
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                tin  = TGT_FIRST_CH + chan_off;
                tout = ($urandom_range(0, 3) == 0) ? TGT_DISCARD
                                                   : TGT_FIRST_CH + 7'($urandom_range(0, 15));
            end
            3, 4, 5: begin
                tin = TGT_FIRST_CC + cc;
                case ($urandom_range(0, 3))
                    0:       tout = TGT_DISCARD;
                    1:       tout = TGT_CHAN_AT;
                    default: tout = TGT_FIRST_CC + 7'($urandom_range(0, 63));
                endcase
            end
            6, 7: begin
                tin  = TGT_CHAN_AT;
                tout = ($urandom_range(0, 3) == 0) ? TGT_DISCARD : TGT_FIRST_CC + cc;
            end
            8: begin
                case ($urandom_range(0, 2))
                    0:       tin = TGT_KEY_AT;
                    1:       tin = TGT_PROG;
                    default: tin = TGT_PROG + 7'd1;
                endcase
                tout = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : TGT_DISCARD;
            end
            9, 10: begin
                tin  = 7'($urandom_range(0, 127));
                tout = 7'($urandom_range(0, 127));
            end
            default: begin
                tin  = TGT_FIRST_CH + chan_off;
                tout = 7'($urandom_range(17, 127));
            end
        endcase
        return rule_slot(src, tin, tout);
    endfunction

    function automatic logic [63:0] random_slot_word();
        if ($urandom_range(0, 7) == 0) begin
            return {$urandom, $urandom};
        end
        return {random_rule(), random_rule(), random_rule(), random_rule()};
    endfunction

    function automatic logic [31:0] random_message();
        logic [3:0] kind;
        logic [3:0] chan;
        logic [7:0] d0;
        logic [1:0] len;
        case ($urandom_range(0, 15))
            0:             kind = 4'($urandom_range(0, 7));
            1:             kind = ST_SYSTEM;
            2, 3, 4, 5:    kind = ST_CTRL;
            6, 7, 8:       kind = ST_CHAN_AT;
            default:       kind = 4'($urandom_range(8, 14));
        endcase
        chan = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       d0 = 8'($urandom_range(0, 7));
            1:       d0 = 8'($urandom_range(0, 63));
            2:       d0 = 8'($urandom_range(0, 127));
            default: d0 = 8'($urandom_range(0, 255));
        endcase
        len = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
        return pack_message({kind, chan}, d0, 8'($urandom_range(0, 255)), len,
                            2'($urandom_range(0, 3)));
    endfunction

    task automatic push_message(input logic [31:0] word);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic program_rules(input logic [3:0] count, input logic [63:0] s03,
                                 input logic [63:0] s47, input logic [31:0] s89);
        logic [1:0]  idx [4];
        logic [63:0] val [4];
        int          k;
        idx[0] = REG_RULE_COUNT;
        idx[1] = REG_SLOTS_0_3;
        idx[2] = REG_SLOTS_4_7;
        idx[3] = REG_SLOTS_8_9;
        val[0] = {$urandom, $urandom};
        val[0][3:0] = count;
        val[1] = s03;
        val[2] = s47;
        val[3] = {$urandom, s89};
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [3:0]  count;
        logic [63:0] s89_word;
        int          phase;
        int          n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // more rules than slots, masked-off and out-of-range rules, every action
        program_rules(4'd15,
            {rule_slot(2'd1, TGT_FIRST_CC + 7'd7, TGT_FIRST_CC + 7'd10),
             rule_slot(2'd3, TGT_FIRST_CH + 7'd1, TGT_FIRST_CH + 7'd4),
             rule_slot(2'd3, 7'd90, TGT_DISCARD),
             rule_slot(2'd0, TGT_FIRST_CH, TGT_DISCARD)},
            {rule_slot(2'd3, TGT_PROG, TGT_DISCARD),
             rule_slot(2'd3, TGT_KEY_AT, TGT_DISCARD),
             rule_slot(2'd2, TGT_LAST_CC, TGT_CHAN_AT),
             rule_slot(2'd3, TGT_CHAN_AT, TGT_FIRST_CC + 7'd1)},
            {rule_slot(2'd3, TGT_FIRST_CH + 7'd15, TGT_DISCARD),
             rule_slot(2'd3, TGT_PROG + 7'd1, TGT_DISCARD)});
        push_message(pack_message(8'h91, 8'd60, 8'd100, 2'd2, 2'd1));
        push_message(pack_message(8'hB0, 8'd7, 8'd64, 2'd2, 2'd1));
        push_message(pack_message(8'hB0, 8'd7, 8'd64, 2'd2, 2'd2));
        push_message(pack_message(8'hD3, 8'h45, 8'h00, 2'd1, 2'd3));
        push_message(pack_message(8'hB5, 8'd63, 8'h7F, 2'd2, 2'd2));
        push_message(pack_message(8'hA0, 8'd10, 8'd20, 2'd2, 2'd1));
        push_message(pack_message(8'hC2, 8'd5, 8'd0, 2'd1, 2'd2));
        push_message(pack_message(8'hEF, 8'h7F, 8'h7F, 2'd2, 2'd3));
        push_message(pack_message(8'h8F, 8'd0, 8'd0, 2'd2, 2'd3));
        push_message(pack_message(8'hF8, 8'd0, 8'd0, 2'd0, 2'd3));
        push_message(pack_message(8'hF0, 8'hFF, 8'hFF, 2'd3, 2'd3));
        push_message(pack_message(8'h00, 8'h80, 8'hFF, 2'd3, 2'd3));
        push_message(pack_message(8'h7F, 8'hFF, 8'h00, 2'd2, 2'd1));
        push_message(pack_message(8'h90, 8'h00, 8'h00, 2'd0, 2'd0));
        push_message(pack_message(8'h91, 8'd200, 8'd1, 2'd2, 2'd2));
        wait_idle();

        // no active rules, slots at both extremes
        program_rules(4'd0, 64'h0, {64{1'b1}}, {32{1'b1}});
        push_message(pack_message(8'h91, 8'd60, 8'd100, 2'd2, 2'd3));
        push_message(pack_message(8'hB0, 8'd7, 8'd64, 2'd2, 2'd1));
        push_message(32'h0FFF_FFFF);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            quiet = (phase == 7);
            case (phase)
                0:       count = 4'd10;
                1:       count = 4'd15;
                2:       count = 4'd0;
                default: count = 4'($urandom_range(0, 15));
            endcase
            s89_word = random_slot_word();
            program_rules(count, random_slot_word(), random_slot_word(), s89_word[31:0]);
            for (n = 0; n < 250; n++) begin
                if (phase == 3 && n == 125) begin
                    wait_idle();
                end
                push_message(random_message());
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[midi_rule_filter_mapper_unit] OK");
        end else begin
            $display("[midi_rule_filter_mapper_unit] ERROR");
        end
        $finish;
    end

endmodule
